### sv/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths and types for the L1 subgradient distance unit.
// ----------------------------------------------------------------------------
package lsd_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int SCALE_WIDTH = DATA_WIDTH - 1;
   localparam int SUM_WIDTH   = 2 * DATA_WIDTH;
   localparam int ROOT_WIDTH  = SUM_WIDTH / 2;
   localparam int REM_WIDTH   = ROOT_WIDTH + 3;
   localparam int STEP_WIDTH  = $clog2(ROOT_WIDTH);
   localparam int QDEPTH      = 4;
   localparam int QPTR_WIDTH  = $clog2(QDEPTH);
   localparam int QCNT_WIDTH  = QPTR_WIDTH + 1;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] mag;
      logic                  last;
   } term_type;

   typedef struct packed {
      logic                  full;
      logic                  empty;
      logic [QCNT_WIDTH-1:0] count;
   } queue_stat_type;

   typedef struct packed {
      logic                 start;
      logic [SUM_WIDTH-1:0] radicand;
      logic                 flag;
   } root_req_type;

endpackage

### sv/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front
// Classifies one element and forms the magnitude of its distance term.
// ----------------------------------------------------------------------------
module lsd_front (
   input  logic signed [lsd_pkg::DATA_WIDTH-1:0]  dual_value,
   input  logic signed [lsd_pkg::DATA_WIDTH-1:0]  primal_value,
   input  logic signed [lsd_pkg::DATA_WIDTH-1:0]  center_value,
   input  logic                                   last,
   input  logic        [lsd_pkg::SCALE_WIDTH-1:0] scale,
   output lsd_pkg::term_type                      term
);

   localparam int DW = lsd_pkg::DATA_WIDTH;

   logic signed [DW+1:0] d_ext;
   logic signed [DW+1:0] s_ext;
   logic signed [DW+1:0] d_minus;
   logic signed [DW+1:0] d_plus;
   logic signed [DW+1:0] sel;
   logic signed [DW+1:0] neg;

   always_comb begin
      d_ext   = {{2{dual_value[DW-1]}}, dual_value};
      s_ext   = {3'b000, scale};
      d_minus = d_ext - s_ext;
      d_plus  = d_ext + s_ext;
      if (primal_value > center_value) begin
         sel = d_minus;
      end else if (primal_value < center_value) begin
         sel = d_plus;
      end else if (d_plus < 0) begin
         sel = d_plus;
      end else if (d_minus > 0) begin
         sel = d_minus;
      end else begin
         sel = '0;
      end
      neg       = -sel;
      term.mag  = sel[DW+1] ? neg[DW-1:0] : sel[DW-1:0];
      term.last = last;
   end

endmodule

### sv/lsd_queue.sv
// ----------------------------------------------------------------------------
// lsd_queue
// Short first-in first-out queue of classified terms between front and back.
// ----------------------------------------------------------------------------
module lsd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lsd_pkg::term_type       wdata,
   input  logic                    pop,
   output lsd_pkg::term_type       rdata,
   output lsd_pkg::queue_stat_type stat
);

   lsd_pkg::term_type                  mem_ff [lsd_pkg::QDEPTH];
   logic [lsd_pkg::QPTR_WIDTH-1:0]     wr_ptr_ff;
   logic [lsd_pkg::QPTR_WIDTH-1:0]     wr_ptr_in;
   logic [lsd_pkg::QPTR_WIDTH-1:0]     rd_ptr_ff;
   logic [lsd_pkg::QPTR_WIDTH-1:0]     rd_ptr_in;
   logic [lsd_pkg::QCNT_WIDTH-1:0]     count_ff;
   logic [lsd_pkg::QCNT_WIDTH-1:0]     count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      rdata      = mem_ff[rd_ptr_ff];
      stat.count = count_ff;
      stat.full  = (count_ff == lsd_pkg::QCNT_WIDTH'(lsd_pkg::QDEPTH));
      stat.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/lsd_back.sv
// ----------------------------------------------------------------------------
// lsd_back
// Squares each term and sums into a saturating Q32.32 accumulator; hands the
// final sum of a frame to the root unit.
// ----------------------------------------------------------------------------
module lsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lsd_pkg::term_type     q_rdata,
   input  logic                  q_empty,
   input  logic                  root_busy,
   output logic                  pop,
   output lsd_pkg::root_req_type root_req
);

   localparam int SW = lsd_pkg::SUM_WIDTH;

   logic          a_valid_ff;
   logic          a_valid_in;
   logic          a_last_ff;
   logic          a_last_in;
   logic [SW-1:0] a_sq_ff;
   logic [SW-1:0] a_sq_in;
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] sum_in;
   logic          flag_ff;
   logic          flag_in;
   logic [SW:0]   sum_wide;
   logic [SW-1:0] sum_next;
   logic          flag_next;
   logic          b_take;
   logic          a_ready;

   always_comb begin
      b_take    = a_valid_ff && (!a_last_ff || !root_busy);
      a_ready   = !a_valid_ff || b_take;
      pop       = a_ready && !q_empty;
      a_valid_in = a_valid_ff;
      a_last_in  = a_last_ff;
      a_sq_in    = a_sq_ff;
      if (a_ready) begin
         a_valid_in = !q_empty;
         a_last_in  = q_rdata.last;
         a_sq_in    = SW'(q_rdata.mag) * SW'(q_rdata.mag);
      end

      sum_wide  = {1'b0, sum_ff} + {1'b0, a_sq_ff};
      sum_next  = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
      flag_next = flag_ff | sum_wide[SW];

      sum_in            = sum_ff;
      flag_in           = flag_ff;
      root_req.start    = 1'b0;
      root_req.radicand = sum_next;
      root_req.flag     = flag_next;
      if (b_take) begin
         if (a_last_ff) begin
            sum_in         = '0;
            flag_in        = 1'b0;
            root_req.start = 1'b1;
         end else begin
            sum_in  = sum_next;
            flag_in = flag_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_sq_ff   <= a_sq_in;
      a_last_ff <= a_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         sum_ff     <= '0;
         flag_ff    <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         sum_ff     <= sum_in;
         flag_ff    <= flag_in;
      end
   end

endmodule

### sv/lsd_root.sv
// ----------------------------------------------------------------------------
// lsd_root
// Bit-serial integer square root, one result bit per cycle, with the
// result output register.
// ----------------------------------------------------------------------------
module lsd_root (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsd_pkg::root_req_type                 root_req,
   input  logic                                  rsp_tready,
   output logic                                  busy,
   output logic                                  rsp_tvalid,
   output logic [lsd_pkg::ROOT_WIDTH-1:0]        rsp_tdata,
   output logic [0:0]                            rsp_tuser
);

   localparam int SW = lsd_pkg::SUM_WIDTH;
   localparam int RW = lsd_pkg::ROOT_WIDTH;
   localparam int MW = lsd_pkg::REM_WIDTH;
   localparam int CW = lsd_pkg::STEP_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]    state_ff;
   logic [1:0]    state_in;
   logic [SW-1:0] rad_ff;
   logic [SW-1:0] rad_in;
   logic [MW-1:0] rem_ff;
   logic [MW-1:0] rem_in;
   logic [RW-1:0] root_ff;
   logic [RW-1:0] root_in;
   logic [CW-1:0] step_ff;
   logic [CW-1:0] step_in;
   logic          flag_ff;
   logic          flag_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [RW-1:0] out_data_ff;
   logic [RW-1:0] out_data_in;
   logic          out_flag_ff;
   logic          out_flag_in;
   logic [MW-1:0] rem_sh;
   logic [MW-1:0] trial;

   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      flag_in      = flag_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_flag_in  = out_flag_ff;
      rem_sh       = {rem_ff[MW-3:0], rad_ff[SW-1:SW-2]};
      trial        = {1'b0, root_ff, 2'b01};

      unique case (state_ff)
         ST_IDLE: begin
            if (root_req.start) begin
               rad_in   = root_req.radicand;
               flag_in  = root_req.flag;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rad_in  = {rad_ff[SW-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            if (step_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = root_ff;
               out_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy         = (state_ff != ST_IDLE);
      rsp_tvalid   = out_valid_ff;
      rsp_tdata    = out_data_ff;
      rsp_tuser[0] = out_flag_ff;
   end

   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      flag_ff     <= flag_in;
      out_data_ff <= out_data_in;
      out_flag_ff <= out_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### sv/l1_subgradient_distance_unit.sv
// Throughput: one word per cycle into the accumulator while the queue holds words;
// the last word of a frame waits while the root unit is busy. The 32-step
// bit-serial square root overlaps with the next frame. One result per frame.
// Reset: synchronous, active high; clears the sum, the saturation flag and the
// queue, and sets scale to 1.0.
// ----------------------------------------------------------------------------
// l1_subgradient_distance_unit
// Sums squared distance terms of a streamed matrix and returns the root.
// ----------------------------------------------------------------------------
module l1_subgradient_distance_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lsd_pkg::SCALE_WIDTH-1:0]         csr_data,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // dual_value, primal_value, center_value
   input  logic [3*lsd_pkg::DATA_WIDTH-1:0]        req_tdata,
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // distance
   output logic [lsd_pkg::ROOT_WIDTH-1:0]          rsp_tdata,
   // saturated
   output logic [0:0]                              rsp_tuser
);

   localparam int DW = lsd_pkg::DATA_WIDTH;

   logic [lsd_pkg::SCALE_WIDTH-1:0] scale_ff;
   logic [lsd_pkg::SCALE_WIDTH-1:0] scale_in;
   lsd_pkg::term_type               front_term;
   lsd_pkg::term_type               q_rdata;
   lsd_pkg::queue_stat_type         q_stat;
   lsd_pkg::root_req_type           root_req;
   logic                            push;
   logic                            pop;
   logic                            root_busy;

   assign csr_ready  = 1'b1;
   assign scale_in   = (csr_valid && csr_ready) ? csr_data : scale_ff;
   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= lsd_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   lsd_front u_front (
      .dual_value   (req_tdata[DW-1:0]),
      .primal_value (req_tdata[2*DW-1:DW]),
      .center_value (req_tdata[3*DW-1:2*DW]),
      .last         (req_tlast),
      .scale        (scale_ff),
      .term         (front_term)
   );

   lsd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_term),
      .pop   (pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   lsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rdata   (q_rdata),
      .q_empty   (q_stat.empty),
      .root_busy (root_busy),
      .pop       (pop),
      .root_req  (root_req)
   );

   lsd_root u_root (
      .clock      (clock),
      .reset      (reset),
      .root_req   (root_req),
      .rsp_tready (rsp_tready),
      .busy       (root_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= lsd_pkg::QCNT_WIDTH'(lsd_pkg::QDEPTH))
      else $error("queue count past depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      root_req.start |-> !root_busy)
      else $error("root started while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      root_req.start |=> root_busy)
      else $error("root did not start");

endmodule
